/* hdl/cidm_pkg.sv */
// Package for the cut-in disengage monitor: widths, codes, reset values
// and the control/status structs shared by the top level and the window.
// No dependencies.
`timescale 1ns / 1ps

package cidm_pkg;

   localparam int Q_W         = 24;
   localparam int HOLD_W      = 8;
   localparam int CSR_IDX_W   = 2;

   // window keeps the newest WINDOW_LIMIT+1 distance differences
   localparam int WINDOW_LIMIT = 10;
   localparam int WIN_DEPTH    = WINDOW_LIMIT + 1;
   localparam int WIN_IDX_W    = $clog2(WIN_DEPTH);
   localparam int WIN_FILL_W   = $clog2(WIN_DEPTH + 1);

   localparam logic OP_DISTANCE = 1'b0;
   localparam logic OP_COMMAND  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL_FLOOR  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CUT_IN_THR   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_COUNT   = 2'd2;

   localparam logic signed [Q_W-1:0] ACCEL_FLOOR_RST = -24'sd640;   // -2.5
   localparam logic signed [Q_W-1:0] CUT_IN_THR_RST  = -24'sd1280;  // -5.0
   localparam logic [HOLD_W-1:0]     HOLD_COUNT_RST  = 8'd61;

   typedef struct packed {
      logic                 push;
      logic                 rd_en;
      logic [WIN_IDX_W-1:0] rd_addr;
   } win_ctrl_type;

   typedef struct packed {
      logic [WIN_FILL_W-1:0] fill;
   } win_stat_type;

endpackage

/* hdl/cidm_if.sv */
// Handshake channel interfaces: request, response and register write.
// Depends on cidm_pkg.
`timescale 1ns / 1ps

interface cidm_req_if import cidm_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 opcode;
   logic signed [Q_W-1:0] value;
   modport source (output valid, opcode, value, input ready);
   modport sink   (input valid, opcode, value, output ready);
endinterface

interface cidm_rsp_if import cidm_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic signed [Q_W-1:0] safe_accel;
   logic                 cancel_released;
   logic                 cancel_asserted;
   logic                 cancel_active;
   modport source (output valid, safe_accel, cancel_released, cancel_asserted,
                   cancel_active, input ready);
   modport sink   (input valid, safe_accel, cancel_released, cancel_asserted,
                   cancel_active, output ready);
endinterface

interface cidm_csr_if import cidm_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [Q_W-1:0]       data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/cidm_window.sv */
// Difference window: saturating distance delta, circular memory of the
// newest differences, registered read port for the threshold scan.
// Depends on cidm_pkg.
`timescale 1ns / 1ps

module cidm_window import cidm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  win_ctrl_type          ctrl,
   input  logic signed [Q_W-1:0] push_value,
   output logic signed [Q_W-1:0] rd_data,
   output win_stat_type          stat
);

   logic signed [Q_W-1:0] mem [WIN_DEPTH];
   logic signed [Q_W-1:0] rd_data_ff;

   logic [WIN_IDX_W-1:0]  wpos_ff, wpos_in;
   logic [WIN_FILL_W-1:0] fill_ff, fill_in;
   logic signed [Q_W-1:0] prev_ff, prev_in;

   logic signed [Q_W:0]   delta;
   logic signed [Q_W-1:0] diff;

   always_comb begin
      delta = {push_value[Q_W-1], push_value} - {prev_ff[Q_W-1], prev_ff};
      // saturate when the two top bits disagree
      if (delta[Q_W] != delta[Q_W-1]) begin
         diff = delta[Q_W] ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
      end else begin
         diff = delta[Q_W-1:0];
      end
      if (fill_ff == '0) begin
         diff = '0;
      end

      wpos_in = wpos_ff;
      fill_in = fill_ff;
      prev_in = prev_ff;
      if (ctrl.push) begin
         prev_in = push_value;
         wpos_in = (wpos_ff == WIN_IDX_W'(WIN_DEPTH - 1)) ? '0 : wpos_ff + WIN_IDX_W'(1);
         if (fill_ff != WIN_FILL_W'(WIN_DEPTH)) begin
            fill_in = fill_ff + WIN_FILL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wpos_ff <= '0;
         fill_ff <= '0;
         prev_ff <= '0;
      end else begin
         wpos_ff <= wpos_in;
         fill_ff <= fill_in;
         prev_ff <= prev_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         mem[wpos_ff] <= diff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.rd_en) begin
         rd_data_ff <= mem[ctrl.rd_addr];
      end
   end

   assign rd_data   = rd_data_ff;
   assign stat.fill = fill_ff;

endmodule

/* hdl/cut_in_disengage_monitor_top.sv */
// Cut-in disengage monitor top level: command sequencer, cancel latch,
// hold counter, register file and response register.
// Depends on cidm_pkg, cidm_if and cidm_window.
//
//   channel  modport  transaction
//   req_if   sink     opcode + value (distance sample or accel command)
//   rsp_if   source   safe_accel + release/assert/active flags
//   csr_if   sink     register index + write data, always ready
//
// A distance sample is a single window memory write; the sequencer stays idle.
// A command goes from idle to the finish state; below the floor with no hold
// running and a nonempty window it passes the scan and drain states first:
// the window memory's single read port is scanned one entry per cycle.
// Reset is synchronous; no clearing pass, the fill count guards the memory.
// A waiting response stalls only the final cycle of the next command.
`timescale 1ns / 1ps

module cut_in_disengage_monitor_top import cidm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   cidm_req_if.sink   req_if,
   cidm_rsp_if.source rsp_if,
   cidm_csr_if.sink   csr_if
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic signed [Q_W-1:0] floor_ff, thr_ff;
   logic [HOLD_W-1:0]     hold_count_ff;

   logic                  latched_ff, latched_in;
   logic [HOLD_W-1:0]     hold_ff, hold_in;

   logic signed [Q_W-1:0] safe_ff, safe_in;
   logic                  released_ff, released_in;
   logic                  need_ff, need_in;
   logic                  hit_ff, hit_in;
   logic                  rd_vld_ff, rd_vld_in;
   logic [WIN_IDX_W-1:0]  idx_ff, idx_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic signed [Q_W-1:0] rsp_safe_ff, rsp_safe_in;
   logic                  rsp_rel_ff, rsp_rel_in;
   logic                  rsp_asr_ff, rsp_asr_in;
   logic                  rsp_act_ff, rsp_act_in;

   win_ctrl_type          win_ctrl;
   win_stat_type          win_stat;
   logic signed [Q_W-1:0] win_rd_data;

   logic                  req_take;
   logic                  out_free;
   logic                  asserted;
   logic [HOLD_W-1:0]     hold_step;
   logic                  latch_step;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_take     = req_if.valid && req_if.ready;
   assign out_free     = !rsp_valid_ff || rsp_if.ready;
   assign asserted     = need_ff && hit_ff;

   // configuration registers
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         floor_ff      <= ACCEL_FLOOR_RST;
         thr_ff        <= CUT_IN_THR_RST;
         hold_count_ff <= HOLD_COUNT_RST;
      end else if (csr_if.valid) begin
         case (csr_if.index)
            CSR_ACCEL_FLOOR: floor_ff      <= csr_if.data;
            CSR_CUT_IN_THR:  thr_ff        <= csr_if.data;
            CSR_HOLD_COUNT:  hold_count_ff <= csr_if.data[HOLD_W-1:0];
            default: ;
         endcase
      end
   end

   cidm_window u_window (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (win_ctrl),
      .push_value (req_if.value),
      .rd_data    (win_rd_data),
      .stat       (win_stat)
   );

   always_comb begin
      // release step of the latch, taken when the command is accepted
      hold_step  = hold_ff;
      latch_step = latched_ff;
      if (latched_ff) begin
         if (hold_ff >= hold_count_ff) begin
            hold_step  = '0;
            latch_step = 1'b0;
         end else begin
            hold_step = hold_ff + HOLD_W'(1);
         end
      end

      state_in     = state_ff;
      latched_in   = latched_ff;
      hold_in      = hold_ff;
      safe_in      = safe_ff;
      released_in  = released_ff;
      need_in      = need_ff;
      hit_in       = hit_ff;
      idx_in       = idx_ff;
      rd_vld_in    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_safe_in  = rsp_safe_ff;
      rsp_rel_in   = rsp_rel_ff;
      rsp_asr_in   = rsp_asr_ff;
      rsp_act_in   = rsp_act_ff;

      win_ctrl.push    = req_take && (req_if.opcode == OP_DISTANCE);
      win_ctrl.rd_en   = 1'b0;
      win_ctrl.rd_addr = idx_ff;

      // registered read data compared in the cycle after the read
      if (rd_vld_ff && (win_rd_data < thr_ff)) begin
         hit_in = 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take && (req_if.opcode == OP_COMMAND)) begin
               latched_in  = latch_step;
               hold_in     = hold_step;
               released_in = latched_ff && !latch_step;
               safe_in     = latched_ff ? '0 : req_if.value;
               need_in     = (req_if.value < floor_ff) && (hold_step == '0);
               hit_in      = 1'b0;
               idx_in      = '0;
               if ((req_if.value < floor_ff) && (hold_step == '0) &&
                   (win_stat.fill != '0)) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_SCAN: begin
            win_ctrl.rd_en = 1'b1;
            rd_vld_in      = 1'b1;
            idx_in         = idx_ff + WIN_IDX_W'(1);
            if (WIN_FILL_W'(idx_ff) + WIN_FILL_W'(1) == win_stat.fill) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_safe_in  = asserted ? '0 : safe_ff;
               rsp_rel_in   = released_ff;
               rsp_asr_in   = asserted;
               rsp_act_in   = latched_ff || asserted;
               if (asserted) begin
                  latched_in = 1'b1;
                  hold_in    = HOLD_W'(1);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         latched_ff   <= 1'b0;
         hold_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         latched_ff   <= latched_in;
         hold_ff      <= hold_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      safe_ff     <= safe_in;
      released_ff <= released_in;
      need_ff     <= need_in;
      hit_ff      <= hit_in;
      idx_ff      <= idx_in;
      rsp_safe_ff <= rsp_safe_in;
      rsp_rel_ff  <= rsp_rel_in;
      rsp_asr_ff  <= rsp_asr_in;
      rsp_act_ff  <= rsp_act_in;
   end

   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.safe_accel      = rsp_safe_ff;
   assign rsp_if.cancel_released = rsp_rel_ff;
   assign rsp_if.cancel_asserted = rsp_asr_ff;
   assign rsp_if.cancel_active   = rsp_act_ff;

   // an unlatched cancel never leaves a hold count behind
   a_hold_clear: assert property (@(posedge clock) disable iff (reset)
      !latched_ff |-> (hold_ff == '0))
      else $error("hold counter nonzero while cancel not latched");

   // any cancel activity in a transaction zeroes the passed-on command
   a_safe_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && (rsp_if.cancel_active || rsp_if.cancel_asserted ||
                        rsp_if.cancel_released)) |-> (rsp_if.safe_accel == '0))
      else $error("command passed on during cancel");

   // the scan only reads entries already written
   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (WIN_FILL_W'(idx_ff) < win_stat.fill))
      else $error("window scan beyond fill count");

   a_fill_max: assert property (@(posedge clock) disable iff (reset)
      win_stat.fill <= WIN_FILL_W'(WIN_DEPTH))
      else $error("window fill count over depth");

endmodule
